/* rtl/cdm_pkg.sv */
// ----------------------------------------------------------------------------
// cdm_pkg
// Shared constants, register indexes and control types of the drive mixer.
// ----------------------------------------------------------------------------
package cdm_pkg;

  localparam int FRAC_BITS        = 14;
  localparam int REMAP_DEPTH_DEF  = 1024;
  localparam int ROM_W            = FRAC_BITS + 1;

  localparam int IN_W             = 16;
  localparam int OUT_W            = 19;
  localparam int ACC_W            = 20;

  localparam int CFG_ADDR_W       = 3;
  localparam int CFG_DATA_W       = 18;

  // register indexes on the configuration port
  localparam logic [CFG_ADDR_W-1:0] REG_DEADBAND    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SLEW_UP     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SLEW_DOWN   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_INERTIA     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_SENSITIVITY = 3'd4;

  localparam logic [14:0] DEADBAND_RST    = 15'd819;
  localparam logic [14:0] SLEW_UP_RST     = 15'd819;
  localparam logic [15:0] SLEW_DOWN_RST   = 16'd1638;
  localparam logic [17:0] INERTIA_RST     = 18'd65536;
  localparam logic [15:0] SENSITIVITY_RST = 16'd13926;

  typedef struct packed {
    logic [14:0] deadband;
    logic [14:0] slew_up;
    logic [15:0] slew_down;
    logic [17:0] inertia_gain;
    logic [15:0] turn_sensitivity;
  } cfg_t;

  // one step strobe per controller state
  typedef struct packed {
    logic load;
    logic prep;
    logic interp;
    logic mul1;
    logic mul2;
    logic finish;
  } cmd_t;

endpackage

/* rtl/cdm_if.sv */
// ----------------------------------------------------------------------------
// cdm_if
// Valid/ready channels of the drive mixer: samples, results, configuration.
// ----------------------------------------------------------------------------
interface cdm_in_if;
  import cdm_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [IN_W-1:0]  throttle;
  logic signed [IN_W-1:0]  turn;

  modport source (output valid, output throttle, output turn, input ready);
  modport sink   (input valid, input throttle, input turn, output ready);
endinterface

interface cdm_out_if;
  import cdm_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] left_power;
  logic signed [OUT_W-1:0] right_power;
  logic                    spin_in_place;

  modport source (output valid, output left_power, output right_power,
                  output spin_in_place, input ready);
  modport sink   (input valid, input left_power, input right_power,
                  input spin_in_place, output ready);
endinterface

interface cdm_cfg_if;
  import cdm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

/* rtl/cdm_cfg.sv */
// ----------------------------------------------------------------------------
// cdm_cfg
// Configuration register file: decodes writes and masks to register width.
// ----------------------------------------------------------------------------
module cdm_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           valid,
  output logic                           ready,
  input  logic [cdm_pkg::CFG_ADDR_W-1:0] addr,
  input  logic [cdm_pkg::CFG_DATA_W-1:0] data,
  output cdm_pkg::cfg_t                  regs
);
  import cdm_pkg::*;

  assign ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.deadband         <= DEADBAND_RST;
      regs.slew_up          <= SLEW_UP_RST;
      regs.slew_down        <= SLEW_DOWN_RST;
      regs.inertia_gain     <= INERTIA_RST;
      regs.turn_sensitivity <= SENSITIVITY_RST;
    end else if (valid) begin
      case (addr)
        REG_DEADBAND:    regs.deadband         <= data[14:0];
        REG_SLEW_UP:     regs.slew_up          <= data[14:0];
        REG_SLEW_DOWN:   regs.slew_down        <= data[15:0];
        REG_INERTIA:     regs.inertia_gain     <= data[17:0];
        REG_SENSITIVITY: regs.turn_sensitivity <= data[15:0];
        default: begin
          // unknown index, word dropped
        end
      endcase
    end
  end

endmodule

/* rtl/cdm_ctrl.sv */
// ----------------------------------------------------------------------------
// cdm_ctrl
// Sequencer of the drive mixer: steps the shared multiplier through one
// sample and owns the result valid flag.
// ----------------------------------------------------------------------------
module cdm_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output cdm_pkg::cmd_t cmd
);
  import cdm_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PREP   = 3'd1;
  localparam logic [2:0] ST_INTERP = 3'd2;
  localparam logic [2:0] ST_MUL1   = 3'd3;
  localparam logic [2:0] ST_MUL2   = 3'd4;
  localparam logic [2:0] ST_FIN    = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = ST_INTERP;
      end
      ST_INTERP: begin
        cmd.interp = 1'b1;
        state_next = ST_MUL1;
      end
      ST_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        // hold the finished word until the output register is free
        if (!out_valid || out_ready) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.finish) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

/* rtl/cdm_dp.sv */
// ----------------------------------------------------------------------------
// cdm_dp
// Datapath of the drive mixer: deadband and slew decision, turn curve ROM
// with interpolation, one shared multiplier, inertia accumulator and
// saturating output register.
// ----------------------------------------------------------------------------
module cdm_dp #(
  parameter int REMAP_TABLE_DEPTH = cdm_pkg::REMAP_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  cdm_pkg::cfg_t                     cfg,
  input  cdm_pkg::cmd_t                     cmd,
  input  logic signed [cdm_pkg::IN_W-1:0]   throttle,
  input  logic signed [cdm_pkg::IN_W-1:0]   turn,
  output logic signed [cdm_pkg::OUT_W-1:0]  left_power,
  output logic signed [cdm_pkg::OUT_W-1:0]  right_power,
  output logic                              spin_in_place
);
  import cdm_pkg::*;

  localparam int IW = $clog2(REMAP_TABLE_DEPTH + 1);
  localparam int PW = IW + FRAC_BITS;

  localparam logic [63:0] Q30_ONE   = 64'd1073741824;
  localparam logic [63:0] Q30_PI_4  = 64'd843314857;
  localparam logic [63:0] Q30_SQRT2 = 64'd1518500250;

  // sine in q30 by truncating taylor series, argument 0 .. pi/4
  function automatic logic [63:0] sin_q30(input logic [63:0] t);
    logic [63:0]        t2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    t2   = (t * t) >> 30;
    term = t;
    sum  = signed'(t);
    for (int n = 1; n <= 7; n++) begin
      term = (term * t2) >> 30;
      case (n)
        1:       term = term / 64'd6;
        2:       term = term / 64'd20;
        3:       term = term / 64'd42;
        4:       term = term / 64'd72;
        5:       term = term / 64'd110;
        6:       term = term / 64'd156;
        default: term = term / 64'd210;
      endcase
      if (n[0]) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    return (sum < 0) ? 64'd0 : 64'(sum);
  endfunction

  function automatic logic [63:0] half_curve(input logic [63:0] x);
    logic [63:0] s;
    logic [63:0] r;
    s = sin_q30((Q30_PI_4 * x) >> 30);
    r = (s * Q30_SQRT2) >> 30;
    return (r > Q30_ONE) ? Q30_ONE : r;
  endfunction

  function automatic logic [ROM_W-1:0] curve_entry(input int k);
    logic [63:0] x;
    logic [63:0] f;
    x = (64'(k) << 30) / REMAP_TABLE_DEPTH;
    f = half_curve(half_curve(x));
    return ROM_W'((f + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
  endfunction

  logic [ROM_W-1:0] curve_rom [0:REMAP_TABLE_DEPTH];

  for (genvar k = 0; k <= REMAP_TABLE_DEPTH; k++) begin : g_curve
    localparam logic [ROM_W-1:0] ENTRY = curve_entry(k);
    assign curve_rom[k] = ENTRY;
  end

  // shift right rounding half away from zero
  function automatic logic signed [55:0] rshr(input logic signed [55:0] v,
                                              input int n);
    logic signed [55:0] half;
    logic signed [55:0] t;
    half = 56'sd1 <<< (n - 1);
    t    = v + half - signed'({55'd0, v[55]});
    return t >>> n;
  endfunction

  // sample and state
  logic signed [IN_W-1:0]  thr_q;
  logic signed [IN_W-1:0]  trn_q;
  logic signed [IN_W-1:0]  last_thr;
  logic signed [IN_W-1:0]  last_turn;
  logic signed [ACC_W-1:0] acc;

  // per-sample working registers
  logic signed [17:0]       linear_q;
  logic                     spin_q;
  logic [FRAC_BITS-1:0]     frac_q;
  logic [ROM_W-1:0]         rom_lo;
  logic [ROM_W-1:0]         rom_hi;
  logic signed [55:0]       p_q;
  logic signed [ACC_W-1:0]  acc_tmp;
  logic signed [15:0]       r_q;

  // prep step
  logic signed [16:0]   thr_x;
  logic signed [16:0]   trn_x;
  logic [16:0]          athr;
  logic [16:0]          atrn;
  logic                 spin_c;
  logic signed [17:0]   thr18;
  logic signed [17:0]   last18;
  logic signed [17:0]   dthr;
  logic signed [17:0]   up18;
  logic signed [17:0]   dn18;
  logic signed [17:0]   linear_c;
  logic [FRAC_BITS:0]   a_c;
  logic [PW-1:0]        pos;
  logic [IW-1:0]        idx;
  logic [IW-1:0]        idx_hi;
  logic signed [16:0]   dt;

  assign thr_x  = {thr_q[15], thr_q};
  assign trn_x  = {trn_q[15], trn_q};
  assign athr   = 17'(thr_x[16] ? -thr_x : thr_x);
  assign atrn   = 17'(trn_x[16] ? -trn_x : trn_x);
  assign spin_c = (athr < {2'b00, cfg.deadband}) && (atrn > {2'b00, cfg.deadband});

  assign thr18  = {{2{thr_q[15]}}, thr_q};
  assign last18 = {{2{last_thr[15]}}, last_thr};
  assign dthr   = thr18 - last18;
  assign up18   = {3'b000, cfg.slew_up};
  assign dn18   = {2'b00, cfg.slew_down};

  always_comb begin
    if (spin_c) begin
      linear_c = '0;
    end else if (dthr > up18) begin
      linear_c = last18 + up18;
    end else if (dthr < -dn18) begin
      linear_c = last18 - dn18;
    end else begin
      linear_c = thr18;
    end
  end

  // curve lookup position, turn magnitude clamped to 1.0
  assign a_c    = (atrn > 17'(1 << FRAC_BITS)) ? (FRAC_BITS+1)'(1 << FRAC_BITS)
                                               : atrn[FRAC_BITS:0];
  assign pos    = PW'(a_c) * PW'(REMAP_TABLE_DEPTH);
  assign idx    = pos[PW-1:FRAC_BITS];
  assign idx_hi = (idx == IW'(REMAP_TABLE_DEPTH)) ? idx : idx + 1'b1;
  assign dt     = trn_x - {last_turn[15], last_turn};

  // shared multiplier
  logic signed [33:0] mul_a;
  logic signed [21:0] mul_b;
  logic signed [15:0] diff;
  logic signed [17:0] lin_abs;
  logic signed [16:0] r_abs;
  logic signed [20:0] rsum;

  assign diff    = signed'({1'b0, rom_hi}) - signed'({1'b0, rom_lo});
  assign lin_abs = linear_q[17] ? -linear_q : linear_q;
  assign r_abs   = r_q[15] ? -{r_q[15], r_q} : {r_q[15], r_q};
  assign rsum    = {{5{r_q[15]}}, r_q} + {acc_tmp[19], acc_tmp};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.prep) begin
      mul_a = 34'(dt);
      mul_b = {4'b0000, cfg.inertia_gain};
    end else if (cmd.interp) begin
      mul_a = 34'(diff);
      mul_b = {8'b0, frac_q};
    end else if (cmd.mul1) begin
      mul_a = 34'(lin_abs);
      mul_b = {6'b0, cfg.turn_sensitivity};
    end else if (cmd.mul2) begin
      if (spin_q) begin
        mul_a = 34'(r_q);
        mul_b = 22'(r_abs);
      end else begin
        // magnitude times sensitivity still sits in the product register
        mul_a = p_q[33:0];
        mul_b = 22'(rsum);
      end
    end
  end

  // rounded views of the product register
  logic signed [55:0]      rs_one;
  logic signed [55:0]      rs_two;
  logic signed [21:0]      accsum;
  logic signed [ACC_W-1:0] acc_sat;
  logic signed [15:0]      r_mag;
  logic signed [25:0]      ang;
  logic signed [26:0]      left_w;
  logic signed [26:0]      right_w;
  logic signed [ACC_W-1:0] acc_decay;

  assign rs_one = rshr(p_q, FRAC_BITS);
  assign rs_two = rshr(p_q, 2 * FRAC_BITS);

  assign accsum = rs_one[21:0] + {{2{acc[19]}}, acc};

  always_comb begin
    if (accsum > 22'sd524287) begin
      acc_sat = 20'sd524287;
    end else if (accsum < -22'sd524288) begin
      acc_sat = -20'sd524288;
    end else begin
      acc_sat = accsum[19:0];
    end
  end

  assign r_mag = signed'({1'b0, rom_lo}) + rs_one[15:0];

  // in spin mode linear is zero, so both modes share the final sum
  assign ang     = spin_q ? rs_one[25:0] : rs_two[25:0];
  assign left_w  = {linear_q[17], linear_q[17], linear_q[17], linear_q[17], linear_q[17],
                    linear_q[17], linear_q[17], linear_q[17], linear_q[17], linear_q}
                   + {ang[25], ang};
  assign right_w = {linear_q[17], linear_q[17], linear_q[17], linear_q[17], linear_q[17],
                    linear_q[17], linear_q[17], linear_q[17], linear_q[17], linear_q}
                   - {ang[25], ang};

  always_comb begin
    if (acc_tmp > 20'sd16384) begin
      acc_decay = acc_tmp - 20'sd16384;
    end else if (acc_tmp < -20'sd16384) begin
      acc_decay = acc_tmp + 20'sd16384;
    end else begin
      acc_decay = '0;
    end
  end

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [26:0] x);
    if (x > 27'sd262143) begin
      return 19'sd262143;
    end else if (x < -27'sd262144) begin
      return -19'sd262144;
    end
    return x[OUT_W-1:0];
  endfunction

  // state carried between samples
  always_ff @(posedge clk) begin
    if (rst) begin
      last_thr  <= '0;
      last_turn <= '0;
      acc       <= '0;
    end else if (cmd.finish) begin
      last_thr  <= thr_q;
      last_turn <= trn_q;
      if (!spin_q) begin
        acc <= acc_decay;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      thr_q <= throttle;
      trn_q <= turn;
    end
    if (cmd.prep) begin
      linear_q <= linear_c;
      spin_q   <= spin_c;
      frac_q   <= pos[FRAC_BITS-1:0];
      rom_lo   <= curve_rom[idx];
      rom_hi   <= curve_rom[idx_hi];
    end
    if (cmd.prep || cmd.interp || cmd.mul1 || cmd.mul2) begin
      p_q <= mul_a * mul_b;
    end
    if (cmd.interp) begin
      acc_tmp <= acc_sat;
    end
    if (cmd.mul1) begin
      r_q <= trn_q[15] ? -r_mag : r_mag;
    end
    if (cmd.finish) begin
      left_power    <= sat_out(left_w);
      right_power   <= sat_out(right_w);
      spin_in_place <= spin_q;
    end
  end

endmodule

/* rtl/cheesy_drive_mixer.sv */
// Arcade drive mixer for joystick samples in signed Q1.14. One sample is taken
// at a time: it is accepted when the block is idle, then a sequencer walks one
// shared 34x22 multiplier through four products (inertia step, curve
// interpolation, throttle times sensitivity, final angular or spin product)
// and a last step rounds, mixes and saturates. A sample occupies the block
// from acceptance through the prep, interp, mul1, mul2 and finish steps; the
// result is registered at finish and stays there until taken, and a finished
// result waits in the last step while the previous one is still unread. The
// turn curve is a constant table of REMAP_TABLE_DEPTH+1 entries built at
// elaboration and read at two addresses at once. Configuration writes are
// always accepted and should be made only while no sample is in flight.
// ----------------------------------------------------------------------------
// cheesy_drive_mixer
// Top level: configuration registers, sequencer and datapath.
// ----------------------------------------------------------------------------
module cheesy_drive_mixer #(
  parameter int REMAP_TABLE_DEPTH = cdm_pkg::REMAP_DEPTH_DEF
) (
  input logic       clk,
  input logic       rst,
  cdm_cfg_if.sink   cfg,
  cdm_in_if.sink    sample,
  cdm_out_if.source result
);
  import cdm_pkg::*;

  cfg_t cfg_regs;
  cmd_t cmd;

  cdm_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .valid (cfg.valid),
    .ready (cfg.ready),
    .addr  (cfg.addr),
    .data  (cfg.data),
    .regs  (cfg_regs)
  );

  cdm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd)
  );

  cdm_dp #(
    .REMAP_TABLE_DEPTH (REMAP_TABLE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg_regs),
    .cmd           (cmd),
    .throttle      (sample.throttle),
    .turn          (sample.turn),
    .left_power    (result.left_power),
    .right_power   (result.right_power),
    .spin_in_place (result.spin_in_place)
  );

  // no second sample while one is being worked on
  a_busy_after_load: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> !sample.ready)
    else $error("sample taken while busy");

  a_step_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.prep, cmd.interp, cmd.mul1, cmd.mul2, cmd.finish}))
    else $error("more than one step strobe");

  a_valid_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(cmd.finish))
    else $error("result valid without a finished word");

  a_spin_mirror: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.spin_in_place |-> result.right_power == -result.left_power)
    else $error("spin powers not mirrored");

endmodule
